### sv/bvdpm_pkg.sv
// ----------------------------------------------------------------------------
// bvdpm_pkg: shared types and constants
// Mode and register codes, byte lane geometry, datapath widths and the
// control word that travels with each store read.
// ----------------------------------------------------------------------------
package bvdpm_pkg;

	localparam int LANES  = 8;   // bytes per store word
	localparam int LANE_W = 3;
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 8;   // holds a length up to 128
	localparam int PROD_W = 16;  // byte times byte
	localparam int PSUM_W = 19;  // sum of one word of products
	localparam int ACC_W  = 23;  // 128 * 255 * 255 fits
	localparam int SQ_W   = 32;  // scale squared, Q0.32
	localparam int DOT_W  = 55;

	// input modes
	localparam logic [1:0] MODE_WR_A  = 2'd0;
	localparam logic [1:0] MODE_WR_B  = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_LENGTH  = 2'd0;
	localparam logic [1:0] CFG_SCALE   = 2'd1;
	localparam logic [1:0] CFG_COUNT_A = 2'd2;
	localparam logic [1:0] CFG_COUNT_B = 2'd3;

	// control that rides along with one store word read
	typedef struct packed {
		logic             valid;
		logic             last;
		logic [LANES-1:0] lane_mask;
	} mac_ctl_t;

	function automatic logic [LEN_W-1:0] len_of_code(input logic [1:0] code);
		logic [LEN_W-1:0] len;
		case (code)
			2'd0:    len = 8'd16;
			2'd1:    len = 8'd32;
			2'd2:    len = 8'd64;
			default: len = 8'd128;
		endcase
		return len;
	endfunction

endpackage

### sv/bvdpm_store.sv
// ----------------------------------------------------------------------------
// bvdpm_store: byte vector store
// Single-port-write memory of 8-byte words with per-byte writes and a
// registered full-word read.
// ----------------------------------------------------------------------------
module bvdpm_store import bvdpm_pkg::*; #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [LANE_W-1:0]        wlane,
	input  logic [BYTE_W-1:0]        wdata,
	input  logic                     re,
	input  logic [AW-1:0]            raddr,
	output logic [LANES*BYTE_W-1:0]  rdata
);

	logic [LANES-1:0][BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr][wlane] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/bvdpm_mac.sv
// ----------------------------------------------------------------------------
// bvdpm_mac: byte multiply-accumulate
// Eight lane products per word, registered, then summed into the query
// accumulator. Masked lanes contribute zero.
// ----------------------------------------------------------------------------
module bvdpm_mac import bvdpm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clear,
	input  mac_ctl_t                 ctl,
	input  logic [LANES*BYTE_W-1:0]  a_word,
	input  logic [LANES*BYTE_W-1:0]  b_word,
	output logic [ACC_W-1:0]         acc,
	output logic                     acc_done
);

	logic [PROD_W-1:0] prod_s2 [LANES];
	mac_ctl_t          ctl_s2;
	logic [PSUM_W-1:0] psum;
	logic [ACC_W-1:0]  acc_q;
	logic              acc_done_q;

	// stage 2: lane products
	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			prod_s2[l] <= ctl.lane_mask[l]
				? PROD_W'(a_word[l*BYTE_W +: BYTE_W]) * PROD_W'(b_word[l*BYTE_W +: BYTE_W])
				: '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl;
		end
	end

	always_comb begin
		psum = '0;
		for (int l = 0; l < LANES; l++) begin
			psum = psum + PSUM_W'(prod_s2[l]);
		end
	end

	// stage 3: accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			acc_done_q <= 1'b0;
		end else begin
			acc_done_q <= ctl_s2.valid & ctl_s2.last;
			if (clear) begin
				acc_q <= '0;
			end else if (ctl_s2.valid) begin
				acc_q <= acc_q + ACC_W'(psum);
			end
		end
	end

	assign acc      = acc_q;
	assign acc_done = acc_done_q;

endmodule

### sv/byte_vector_dot_product_matrix.sv
// ----------------------------------------------------------------------------
// byte_vector_dot_product_matrix: scaled dot product of stored byte vectors
// Two byte-vector stores loaded one element per transaction; a query
// returns sum(A[i][e] * B[j][e]) * scale^2 as unsigned Q23.32.
// ----------------------------------------------------------------------------
// Usage and timing. An input transaction is taken at a clock edge where start
// is high and busy is low. Element writes (mode 0 to store A, mode 1 to store
// B) take effect at that edge and leave busy low, so writes can stream at
// one per clock while busy is low. A query (mode 2) whose A index is not below
// count_a, whose B index is not below count_b, or which exceeds the store
// capacity returns range_error = 1 and dot_value = 0 with done high in the next
// cycle, and leaves busy low. A valid query reads both stores eight bytes per
// cycle; busy is high from acceptance until the accumulator finishes and is
// low again in the cycle in which done is high. The query passes through the
// single 64-bit read port of each store and then the read, product,
// accumulate and final scale-multiply registers. done is a one-cycle strobe
// and the receiver cannot stall it: dot_value and range_error must be
// captured in that cycle. Mode 3 is ignored. Writes outside the capacity or
// with an element index at or beyond MAX_LENGTH are dropped. Stores have no
// reset: a query must only touch elements that were written. Configuration
// (cfg_valid / cfg_ready, always ready) is to be written only while busy is
// low and no result is pending.
// ----------------------------------------------------------------------------
module byte_vector_dot_product_matrix import bvdpm_pkg::*; #(
	parameter int MAX_VECTORS_A = 1024,
	parameter int MAX_VECTORS_B = 1024,
	parameter int MAX_LENGTH    = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	// command channel
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        mode,
	input  logic [9:0]        vector_index,
	input  logic [6:0]        element_index,
	input  logic [7:0]        value,
	input  logic [9:0]        partner_index,
	// results
	output logic              done,
	output logic [DOT_W-1:0]  dot_value,
	output logic              range_error,
	// configuration write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	// store geometry: each vector occupies WPV words of eight bytes
	localparam int WPV     = (MAX_LENGTH + LANES - 1) / LANES;
	localparam int DEPTH_A = MAX_VECTORS_A * WPV;
	localparam int DEPTH_B = MAX_VECTORS_B * WPV;
	localparam int AW_A    = (DEPTH_A > 1) ? $clog2(DEPTH_A) : 1;
	localparam int AW_B    = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;
	localparam int WC_W    = (WPV > 1) ? $clog2(WPV) : 1;

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;   // one word of each store per cycle
	localparam logic [1:0] ST_WAIT = 2'd2;   // pipeline drain and final scale

	// configuration registers
	logic [1:0]   length_code_q;
	logic [15:0]  scale_q;
	logic [10:0]  count_a_q;
	logic [10:0]  count_b_q;

	// sequencer
	logic [1:0]        state_q;
	logic [WC_W-1:0]   word_q;
	logic [WC_W-1:0]   last_word_q;
	logic [LEN_W-1:0]  len_q;
	logic [AW_A-1:0]   base_a_q;
	logic [AW_B-1:0]   base_b_q;
	logic [SQ_W-1:0]   sq_q;

	// result registers
	logic              done_q;
	logic [DOT_W-1:0]  dot_value_q;
	logic              range_error_q;

	// decoded command
	logic              accept;
	logic              we_a;
	logic              we_b;
	logic              query_ok;
	logic              query_err;
	logic [LEN_W-1:0]  len_tab;
	logic [LEN_W-1:0]  len_sat;
	logic [LEN_W-1:0]  len_m1;
	logic [AW_A-1:0]   waddr_a;
	logic [AW_B-1:0]   waddr_b;
	logic [AW_A-1:0]   raddr_a;
	logic [AW_B-1:0]   raddr_b;
	logic              reading;

	mac_ctl_t          ctl_issue;
	mac_ctl_t          ctl_s1;
	logic [LANES*BYTE_W-1:0] rdata_a;
	logic [LANES*BYTE_W-1:0] rdata_b;
	logic [ACC_W-1:0]  acc;
	logic              acc_done;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start & ~busy;
	assign cfg_ready = 1'b1;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_code_q <= 2'd3;
			scale_q       <= 16'd128;
			count_a_q     <= '0;
			count_b_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LENGTH:  length_code_q <= cfg_data[1:0];
				CFG_SCALE:   scale_q       <= cfg_data;
				CFG_COUNT_A: count_a_q     <= cfg_data[10:0];
				CFG_COUNT_B: count_b_q     <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------- command decode
	always_comb begin
		we_a      = 1'b0;
		we_b      = 1'b0;
		query_ok  = 1'b0;
		query_err = 1'b0;
		if (accept) begin
			unique case (mode)
				MODE_WR_A: begin
					we_a = (32'(vector_index) < 32'(MAX_VECTORS_A))
						&& (32'(element_index) < 32'(MAX_LENGTH));
				end
				MODE_WR_B: begin
					we_b = (32'(vector_index) < 32'(MAX_VECTORS_B))
						&& (32'(element_index) < 32'(MAX_LENGTH));
				end
				MODE_QUERY: begin
					if ((11'(vector_index) >= count_a_q)
						|| (11'(partner_index) >= count_b_q)
						|| (32'(vector_index) >= 32'(MAX_VECTORS_A))
						|| (32'(partner_index) >= 32'(MAX_VECTORS_B))) begin
						query_err = 1'b1;
					end else begin
						query_ok = 1'b1;
					end
				end
				default: ;   // unused mode, dropped
			endcase
		end
	end

	// active length, clipped to what a vector can hold
	assign len_tab = len_of_code(length_code_q);
	assign len_sat = (32'(len_tab) > 32'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : len_tab;
	assign len_m1  = len_sat - LEN_W'(1);

	// element e of vector v sits in word v*WPV + e/8, byte lane e%8
	assign waddr_a = AW_A'(32'(vector_index) * WPV + 32'(element_index >> LANE_W));
	assign waddr_b = AW_B'(32'(vector_index) * WPV + 32'(element_index >> LANE_W));

	// ------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			word_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					word_q <= '0;
					if (query_ok) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (word_q == last_word_q) begin
						state_q <= ST_WAIT;
					end else begin
						word_q <= word_q + WC_W'(1);
					end
				end
				ST_WAIT: begin
					if (acc_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// query operands, held for the whole query
	always_ff @(posedge clk) begin
		if (query_ok) begin
			last_word_q <= WC_W'(len_m1 >> LANE_W);
			len_q       <= len_sat;
			base_a_q    <= AW_A'(32'(vector_index) * WPV);
			base_b_q    <= AW_B'(32'(partner_index) * WPV);
			sq_q        <= SQ_W'(scale_q) * SQ_W'(scale_q);
		end
	end

	assign reading = (state_q == ST_READ);
	assign raddr_a = base_a_q + AW_A'(word_q);
	assign raddr_b = base_b_q + AW_B'(word_q);

	// lanes past the active length in the final word are dropped
	always_comb begin
		ctl_issue.valid = reading;
		ctl_issue.last  = (word_q == last_word_q);
		for (int l = 0; l < LANES; l++) begin
			ctl_issue.lane_mask[l] = reading
				&& ((32'(word_q) * LANES + l) < 32'(len_q));
		end
	end

	// aligns control with the registered store read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_issue;
		end
	end

	// ---------------------------------------------------------------- stores
	bvdpm_store #(
		.DEPTH (DEPTH_A),
		.AW    (AW_A)
	) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr_a),
		.wlane (element_index[LANE_W-1:0]),
		.wdata (value),
		.re    (reading),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	bvdpm_store #(
		.DEPTH (DEPTH_B),
		.AW    (AW_B)
	) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr_b),
		.wlane (element_index[LANE_W-1:0]),
		.wdata (value),
		.re    (reading),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	// --------------------------------------------------------- product / sum
	bvdpm_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (query_ok),
		.ctl      (ctl_s1),
		.a_word   (rdata_a),
		.b_word   (rdata_b),
		.acc      (acc),
		.acc_done (acc_done)
	);

	// ---------------------------------------------------------------- result
	// Final scale: 23-bit integer sum times Q0.32 scale squared, exact in 55b.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= query_err | (acc_done & (state_q == ST_WAIT));
		end
	end

	always_ff @(posedge clk) begin
		if (query_err) begin
			dot_value_q   <= '0;
			range_error_q <= 1'b1;
		end else if (acc_done) begin
			dot_value_q   <= DOT_W'(acc) * DOT_W'(sq_q);
			range_error_q <= 1'b0;
		end
	end

	assign done        = done_q;
	assign dot_value   = dot_value_q;
	assign range_error = range_error_q;

	// ------------------------------------------------------------ assertions
	// an accepted query either goes busy or reports at once
	a_query_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == MODE_QUERY) |=> (busy || done))
		else $error("query neither started nor reported");

	// the sequencer only leaves a query by delivering its result
	a_busy_ends_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("query ended without a result");

	// accumulator completes only while the sequencer waits for it
	a_acc_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		acc_done |-> (state_q == ST_WAIT))
		else $error("accumulator finished outside a query");

	// an out-of-range result carries a zero value
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && range_error) |-> (dot_value == '0))
		else $error("range error with nonzero value");

endmodule
